// ===== src/crt_pkg.sv =====
`default_nettype none

package crt_pkg;

  // Defaults for the top-level parameters
  localparam int SYMBOL_ENTRIES_DEF = 256;
  localparam int STACK_ENTRIES_DEF  = 128;
  localparam int ADDRESS_BITS_DEF   = 32;

  // Fixed field widths
  localparam int COUNT_W  = 9;
  localparam int INDEX_W  = 8;
  localparam int FIELD_W  = 32;
  localparam int KIND_W   = 3;
  localparam int REPORT_W = 8;

  // Input word layout, lowest bit first
  localparam int IN_TDATA_W    = 144;
  localparam int OFF_INDEX     = 0;
  localparam int OFF_START     = OFF_INDEX + INDEX_W;
  localparam int OFF_LENGTH    = OFF_START + FIELD_W;
  localparam int OFF_IS_FUNC   = OFF_LENGTH + FIELD_W;
  localparam int OFF_CUR_PC    = OFF_IS_FUNC + 1;
  localparam int OFF_TARGET_PC = OFF_CUR_PC + FIELD_W;

  // Output word layout
  localparam int OUT_TDATA_W = 3 * REPORT_W;

  // Input opcodes carried in tuser
  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_TRANSFER = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    EV_NONE      = 3'd0,
    EV_CALL      = 3'd1,
    EV_RETURN    = 3'd2,
    EV_OVERFLOW  = 3'd3,
    EV_UNMATCHED = 3'd4
  } event_kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CLASS,
    S_POP,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== src/crt_range_unit.sv =====
`default_nettype none

// Shared address compare: key lies in [base, base + len).
// An equality test is the same check with len = 1.
module crt_range_unit #(
  parameter int ADDRESS_BITS = crt_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic [ADDRESS_BITS-1:0]     key,
  input  wire logic [ADDRESS_BITS-1:0]     base,
  input  wire logic [crt_pkg::FIELD_W-1:0] len,
  output logic                             hit
);

  localparam int CW = (ADDRESS_BITS > crt_pkg::FIELD_W) ? ADDRESS_BITS : crt_pkg::FIELD_W;

  logic [ADDRESS_BITS-1:0] diff;
  logic [CW-1:0]           diff_w;
  logic [CW-1:0]           len_w;

  // offset into the range; only meaningful when key >= base
  always_comb begin
    diff   = key - base;
    diff_w = CW'(diff);
    len_w  = CW'(len);
    hit    = (key >= base) && (diff_w < len_w);
  end

endmodule

`default_nettype wire

// ===== src/call_return_tracer.sv =====
`default_nettype none

// Call / return tracer with a shadow return stack.
// Input stream (s_axis_*): tuser selects the word kind. A load word writes
// one symbol table slot; a transfer word gives the executed PC and the next
// PC. Every input word yields exactly one output word (m_axis_*) holding the
// event kind, the from/to symbol slots and the stack depth afterwards.
// symbol_count_we / symbol_count_wdata set how many table slots are searched;
// write it only while the block is idle.
//
// A load word writes its table slot and goes straight to output. A transfer
// word is searched in turn over the searched slots:
// one table port serves a sequential scan for the source function, then
// another for the target, and a pop search walks the stack one entry a
// cycle through its single read port. A transfer to pc+4 skips the searches.
// s_axis_tready is high only while no word is being worked on.
// Reset clears the stack depth, the slot count and the output valid flag;
// the symbol table and stack contents are undefined until written.
// If the receiver stalls, the finished word is held in the output register;
// the next input word is still accepted, and its result waits until the
// register frees.
module call_return_tracer #(
  parameter int SYMBOL_ENTRIES = crt_pkg::SYMBOL_ENTRIES_DEF,
  parameter int STACK_ENTRIES  = crt_pkg::STACK_ENTRIES_DEF,
  parameter int ADDRESS_BITS   = crt_pkg::ADDRESS_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // config register
  input  wire logic                                symbol_count_we,
  input  wire logic [crt_pkg::COUNT_W-1:0]         symbol_count_wdata,
  // input stream
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // entry_index, entry_start, entry_length, entry_is_function, current_pc,
  // target_pc, zero pad
  input  wire logic [crt_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // op
  input  wire logic                                s_axis_tuser,
  // output stream
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // from_symbol, to_symbol, call_depth
  output logic [crt_pkg::OUT_TDATA_W-1:0]          m_axis_tdata,
  // event_kind
  output logic [crt_pkg::KIND_W-1:0]               m_axis_tuser
);

  localparam int AW     = ADDRESS_BITS;
  localparam int FW     = crt_pkg::FIELD_W;
  localparam int CW     = (AW > FW) ? AW : FW;
  localparam int SYM_IW = (SYMBOL_ENTRIES > 1) ? $clog2(SYMBOL_ENTRIES) : 1;
  localparam int SYM_CW = $clog2(SYMBOL_ENTRIES + 1);
  localparam int STK_IW = (STACK_ENTRIES > 1) ? $clog2(STACK_ENTRIES) : 1;
  localparam int STK_CW = $clog2(STACK_ENTRIES + 1);
  localparam int LIM_W  = (SYM_CW > crt_pkg::COUNT_W) ? SYM_CW : crt_pkg::COUNT_W;
  localparam int IDX_W  = (SYM_CW > crt_pkg::INDEX_W) ? SYM_CW : crt_pkg::INDEX_W;
  localparam int SLOT_W = (SYM_IW > crt_pkg::REPORT_W) ? SYM_IW : crt_pkg::REPORT_W;
  localparam int DEP_W  = (STK_CW > crt_pkg::REPORT_W) ? STK_CW : crt_pkg::REPORT_W;
  localparam int ENT_W  = AW + FW + 1;

  // ---------------------------------------------------------------
  // Input word unpacking
  // ---------------------------------------------------------------
  logic [crt_pkg::COUNT_W-1:0]   symbol_count;
  logic                          in_accept;
  logic [crt_pkg::INDEX_W-1:0]   in_index;
  logic [CW-1:0]                 in_start_w;
  logic [CW-1:0]                 in_pc_w;
  logic [CW-1:0]                 in_tgt_w;
  logic [AW-1:0]                 in_start;
  logic [FW-1:0]                 in_length;
  logic                          in_is_func;
  logic [AW-1:0]                 in_pc;
  logic [AW-1:0]                 in_tgt;
  logic [AW-1:0]                 in_ret;
  logic [IDX_W-1:0]              in_index_w;
  logic                          in_index_ok;
  logic [LIM_W-1:0]              count_w;
  logic [LIM_W-1:0]              limit_w;

  always_comb begin
    in_accept   = s_axis_tvalid && s_axis_tready;
    in_index    = s_axis_tdata[crt_pkg::OFF_INDEX +: crt_pkg::INDEX_W];
    in_start_w  = CW'(s_axis_tdata[crt_pkg::OFF_START +: FW]);
    in_length   = s_axis_tdata[crt_pkg::OFF_LENGTH +: FW];
    in_is_func  = s_axis_tdata[crt_pkg::OFF_IS_FUNC];
    in_pc_w     = CW'(s_axis_tdata[crt_pkg::OFF_CUR_PC +: FW]);
    in_tgt_w    = CW'(s_axis_tdata[crt_pkg::OFF_TARGET_PC +: FW]);
    in_start    = in_start_w[AW-1:0];
    in_pc       = in_pc_w[AW-1:0];
    in_tgt      = in_tgt_w[AW-1:0];
    in_ret      = in_pc + AW'(4);
    in_index_w  = IDX_W'(in_index);
    in_index_ok = in_index_w < IDX_W'(SYMBOL_ENTRIES);
    count_w     = LIM_W'(symbol_count);
    limit_w     = (count_w > LIM_W'(SYMBOL_ENTRIES)) ? LIM_W'(SYMBOL_ENTRIES) : count_w;
  end

  // ---------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------
  crt_pkg::state_t          state, state_next;
  logic [STK_CW-1:0]        depth, depth_next;
  logic [AW-1:0]            pc, pc_next;
  logic [AW-1:0]            tgt, tgt_next;
  logic [AW-1:0]            ret_addr, ret_addr_next;
  logic                     phase, phase_next;
  logic [SYM_CW-1:0]        limit, limit_next;
  logic [SYM_CW-1:0]        issue_idx, issue_idx_next;
  logic                     chk_valid, chk_valid_next;
  logic [SYM_IW-1:0]        chk_idx, chk_idx_next;
  logic [STK_CW-1:0]        pop_idx, pop_idx_next;
  logic [STK_IW-1:0]        chk_sidx, chk_sidx_next;
  logic [SYM_IW-1:0]        from_slot, from_slot_next;
  logic [SYM_IW-1:0]        to_slot, to_slot_next;
  logic [AW-1:0]            hit_start, hit_start_next;
  crt_pkg::event_kind_t     res_kind, res_kind_next;
  logic [crt_pkg::REPORT_W-1:0] res_from, res_from_next;
  logic [crt_pkg::REPORT_W-1:0] res_to, res_to_next;
  logic                     out_load;

  // ---------------------------------------------------------------
  // Symbol table memory: {is_function, length, start}
  // ---------------------------------------------------------------
  logic [ENT_W-1:0]  tab_mem [SYMBOL_ENTRIES];
  logic              tab_we;
  logic              tab_rd_en;
  logic [SYM_IW-1:0] tab_wr_addr;
  logic [SYM_IW-1:0] tab_rd_addr;
  logic [ENT_W-1:0]  tab_q;
  logic [AW-1:0]     tab_start;
  logic [FW-1:0]     tab_len;
  logic              tab_is_func;

  always_ff @(posedge clk) begin
    if (tab_we) begin
      tab_mem[tab_wr_addr] <= {in_is_func, in_length, in_start};
    end
    if (tab_rd_en) begin
      tab_q <= tab_mem[tab_rd_addr];
    end
  end

  always_comb begin
    tab_start   = tab_q[AW-1:0];
    tab_len     = tab_q[AW +: FW];
    tab_is_func = tab_q[ENT_W-1];
    tab_wr_addr = in_index_w[SYM_IW-1:0];
    tab_rd_addr = issue_idx[SYM_IW-1:0];
  end

  // ---------------------------------------------------------------
  // Return stack memory
  // ---------------------------------------------------------------
  logic [AW-1:0]     stk_mem [STACK_ENTRIES];
  logic              stk_we;
  logic              stk_rd_en;
  logic [STK_IW-1:0] stk_wr_addr;
  logic [STK_IW-1:0] stk_rd_addr;
  logic [STK_CW-1:0] pop_dec;
  logic [AW-1:0]     stk_q;

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wr_addr] <= ret_addr;
    end
    if (stk_rd_en) begin
      stk_q <= stk_mem[stk_rd_addr];
    end
  end

  always_comb begin
    pop_dec     = pop_idx - STK_CW'(1);
    stk_wr_addr = depth[STK_IW-1:0];
    stk_rd_addr = pop_dec[STK_IW-1:0];
  end

  // ---------------------------------------------------------------
  // Shared compare unit, inputs steered by state
  // ---------------------------------------------------------------
  logic [AW-1:0] cmp_key;
  logic [AW-1:0] cmp_base;
  logic [FW-1:0] cmp_len;
  logic          cmp_hit;

  always_comb begin
    case (state)
      crt_pkg::S_SCAN: begin
        cmp_key  = phase ? tgt : pc;
        cmp_base = tab_start;
        cmp_len  = tab_len;
      end
      crt_pkg::S_CLASS: begin
        cmp_key  = tgt;
        cmp_base = hit_start;
        cmp_len  = FW'(1);
      end
      crt_pkg::S_POP: begin
        cmp_key  = tgt;
        cmp_base = stk_q;
        cmp_len  = FW'(1);
      end
      default: begin
        cmp_key  = tgt;
        cmp_base = hit_start;
        cmp_len  = FW'(1);
      end
    endcase
  end

  crt_range_unit #(
    .ADDRESS_BITS(ADDRESS_BITS)
  ) u_range (
    .key  (cmp_key),
    .base (cmp_base),
    .len  (cmp_len),
    .hit  (cmp_hit)
  );

  // Decode helpers
  logic              scan_hit;
  logic              scan_more;
  logic              pop_hit;
  logic              stack_full;
  logic              same_func;
  logic [SLOT_W-1:0] from_w;
  logic [SLOT_W-1:0] to_w;
  logic [DEP_W-1:0]  depth_w;

  always_comb begin
    scan_hit   = chk_valid && tab_is_func && cmp_hit;
    scan_more  = issue_idx < limit;
    pop_hit    = chk_valid && cmp_hit;
    stack_full = depth == STK_CW'(STACK_ENTRIES);
    same_func  = from_slot == to_slot;
    from_w     = SLOT_W'(from_slot);
    to_w       = SLOT_W'(to_slot);
    depth_w    = DEP_W'(depth);
  end

  // ---------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      crt_pkg::S_IDLE: begin
        if (in_accept) begin
          if (s_axis_tuser == crt_pkg::OP_LOAD || in_tgt == in_ret) begin
            state_next = crt_pkg::S_EMIT;
          end else begin
            state_next = crt_pkg::S_SCAN;
          end
        end
      end
      crt_pkg::S_SCAN: begin
        if (scan_hit && phase) begin
          state_next = crt_pkg::S_CLASS;
        end else if (!scan_hit && !scan_more && !chk_valid) begin
          state_next = crt_pkg::S_EMIT;
        end
      end
      crt_pkg::S_CLASS: begin
        if (!same_func && !cmp_hit && depth != '0) begin
          state_next = crt_pkg::S_POP;
        end else begin
          state_next = crt_pkg::S_EMIT;
        end
      end
      crt_pkg::S_POP: begin
        if (pop_hit || (pop_idx == '0 && !chk_valid)) begin
          state_next = crt_pkg::S_EMIT;
        end
      end
      crt_pkg::S_EMIT: begin
        if (out_load) begin
          state_next = crt_pkg::S_IDLE;
        end
      end
      default: state_next = crt_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------
  // Datapath control
  // ---------------------------------------------------------------
  always_comb begin
    depth_next     = depth;
    pc_next        = pc;
    tgt_next       = tgt;
    ret_addr_next  = ret_addr;
    phase_next     = phase;
    limit_next     = limit;
    issue_idx_next = issue_idx;
    chk_valid_next = chk_valid;
    chk_idx_next   = chk_idx;
    pop_idx_next   = pop_idx;
    chk_sidx_next  = chk_sidx;
    from_slot_next = from_slot;
    to_slot_next   = to_slot;
    hit_start_next = hit_start;
    res_kind_next  = res_kind;
    res_from_next  = res_from;
    res_to_next    = res_to;
    tab_we         = 1'b0;
    tab_rd_en      = 1'b0;
    stk_we         = 1'b0;
    stk_rd_en      = 1'b0;
    s_axis_tready  = 1'b0;
    out_load       = 1'b0;

    case (state)
      crt_pkg::S_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_accept) begin
          res_kind_next  = crt_pkg::EV_NONE;
          res_from_next  = '0;
          res_to_next    = '0;
          pc_next        = in_pc;
          tgt_next       = in_tgt;
          ret_addr_next  = in_ret;
          phase_next     = 1'b0;
          limit_next     = limit_w[SYM_CW-1:0];
          issue_idx_next = '0;
          chk_valid_next = 1'b0;
          tab_we         = (s_axis_tuser == crt_pkg::OP_LOAD) && in_index_ok;
        end
      end

      // one table read issued per cycle, checked the cycle after
      crt_pkg::S_SCAN: begin
        if (scan_hit) begin
          chk_valid_next = 1'b0;
          if (!phase) begin
            from_slot_next = chk_idx;
            phase_next     = 1'b1;
            issue_idx_next = '0;
          end else begin
            to_slot_next   = chk_idx;
            hit_start_next = tab_start;
          end
        end else if (scan_more) begin
          tab_rd_en      = 1'b1;
          chk_valid_next = 1'b1;
          chk_idx_next   = issue_idx[SYM_IW-1:0];
          issue_idx_next = issue_idx + SYM_CW'(1);
        end else begin
          chk_valid_next = 1'b0;
        end
      end

      // no event within one function; call (overflow if full) if the target is its function's start, else return
      crt_pkg::S_CLASS: begin
        if (!same_func) begin
          res_from_next = from_w[crt_pkg::REPORT_W-1:0];
          res_to_next   = to_w[crt_pkg::REPORT_W-1:0];
          if (cmp_hit) begin
            if (stack_full) begin
              res_kind_next = crt_pkg::EV_OVERFLOW;
            end else begin
              stk_we        = 1'b1;
              depth_next    = depth + STK_CW'(1);
              res_kind_next = crt_pkg::EV_CALL;
            end
          end else if (depth == '0) begin
            res_kind_next = crt_pkg::EV_UNMATCHED;
          end else begin
            pop_idx_next   = depth;
            chk_valid_next = 1'b0;
          end
        end
      end

      // walk the stack from the top looking for the target
      crt_pkg::S_POP: begin
        if (pop_hit) begin
          chk_valid_next = 1'b0;
          depth_next     = STK_CW'(chk_sidx);
          res_kind_next  = crt_pkg::EV_RETURN;
        end else if (pop_idx != '0) begin
          stk_rd_en      = 1'b1;
          chk_valid_next = 1'b1;
          chk_sidx_next  = pop_dec[STK_IW-1:0];
          pop_idx_next   = pop_dec;
        end else begin
          chk_valid_next = 1'b0;
          res_kind_next  = crt_pkg::EV_UNMATCHED;
        end
      end

      crt_pkg::S_EMIT: begin
        out_load = !m_axis_tvalid || m_axis_tready;
      end

      default: begin
        chk_valid_next = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= crt_pkg::S_IDLE;
      symbol_count  <= '0;
      depth         <= '0;
      chk_valid     <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state     <= state_next;
      depth     <= depth_next;
      chk_valid <= chk_valid_next;
      if (symbol_count_we) begin
        symbol_count <= symbol_count_wdata;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pc        <= pc_next;
    tgt       <= tgt_next;
    ret_addr  <= ret_addr_next;
    phase     <= phase_next;
    limit     <= limit_next;
    issue_idx <= issue_idx_next;
    chk_idx   <= chk_idx_next;
    pop_idx   <= pop_idx_next;
    chk_sidx  <= chk_sidx_next;
    from_slot <= from_slot_next;
    to_slot   <= to_slot_next;
    hit_start <= hit_start_next;
    res_kind  <= res_kind_next;
    res_from  <= res_from_next;
    res_to    <= res_to_next;
    if (out_load) begin
      m_axis_tuser <= res_kind;
      m_axis_tdata <= {depth_w[crt_pkg::REPORT_W-1:0], res_to, res_from};
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= STK_CW'(STACK_ENTRIES))
    else $error("stack depth beyond capacity");

  a_depth_source: assert property (@(posedge clk) disable iff (rst)
    (depth != $past(depth)) |->
      ($past(state) == crt_pkg::S_CLASS || $past(state) == crt_pkg::S_POP))
    else $error("stack depth changed outside classify/pop");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    stk_we |-> (depth < STK_CW'(STACK_ENTRIES)))
    else $error("push into a full stack");

  a_scan_limit: assert property (@(posedge clk) disable iff (rst)
    (state == crt_pkg::S_SCAN && chk_valid) |-> (SYM_CW'(chk_idx) < limit))
    else $error("table check beyond searched slot count");

  a_pop_below_depth: assert property (@(posedge clk) disable iff (rst)
    (state == crt_pkg::S_POP && chk_valid) |-> (STK_CW'(chk_sidx) < depth))
    else $error("pop search above stack top");

endmodule

`default_nettype wire

// ===== bench/call_return_tracer_tb.sv =====
`default_nettype none

module call_return_tracer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SYMS        = crt_pkg::SYMBOL_ENTRIES_DEF;
  localparam int STACK_DEPTH = crt_pkg::STACK_ENTRIES_DEF;
  localparam int IN_W        = crt_pkg::IN_TDATA_W;
  // worst transfer: two full table scans plus a full stack walk
  localparam int END_SLACK   = 2 * (SYMS + 1) + STACK_DEPTH + 8;
  localparam int CYCLE_LIMIT = 8_000_000;

  // input word fields, entry_index in the lowest bits
  typedef struct packed {
    logic [31:0] target_pc;
    logic [31:0] current_pc;
    logic        is_function;
    logic [31:0] length;
    logic [31:0] start;
    logic [7:0]  index;
  } trace_word_t;

  typedef struct {
    crt_pkg::event_kind_t kind;
    logic [7:0]  from_sym;
    logic [7:0]  to_sym;
    logic [7:0]  depth;
  } trace_event_t;

  // Tracks the symbol table and shadow stack, predicts each result word
  class call_trace_scoreboard;
    logic [31:0]  sym_start  [SYMS];
    logic [31:0]  sym_length [SYMS];
    logic         sym_is_func[SYMS];
    logic [31:0]  ret_stack  [STACK_DEPTH];
    int unsigned  depth;
    int unsigned  symbol_count;
    trace_event_t expected_events[$];
    int unsigned  errors, checked, calls, returns, overflows, unmatched;

    function new();
      depth = 0;
      symbol_count = 0;
      errors = 0;
      checked = 0;
      calls = 0;
      returns = 0;
      overflows = 0;
      unmatched = 0;
    endfunction

    function void flag_error(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    // first function entry among the searched slots that holds addr
    function bit owning_function(logic [31:0] addr, output int unsigned slot);
      int unsigned lim;
      lim = (symbol_count > SYMS) ? SYMS : symbol_count;
      slot = 0;
      for (int unsigned i = 0; i < lim; i++) begin
        if (sym_is_func[i] && sym_start[i] <= addr &&
            addr - sym_start[i] < sym_length[i]) begin
          slot = i;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function void note_word(logic op, trace_word_t w);
      trace_event_t e;
      logic [31:0]  ret_addr;
      int unsigned  from_slot, to_slot;
      bit           from_hit, to_hit, found;
      int           d;
      e.kind = crt_pkg::EV_NONE;
      e.from_sym = '0;
      e.to_sym = '0;
      if (op == crt_pkg::OP_LOAD) begin
        sym_start[w.index]   = w.start;
        sym_length[w.index]  = w.length;
        sym_is_func[w.index] = w.is_function;
      end else begin
        ret_addr = w.current_pc + 32'd4;
        from_hit = owning_function(w.current_pc, from_slot);
        to_hit   = owning_function(w.target_pc, to_slot);
        if (w.target_pc != ret_addr && from_hit && to_hit && from_slot != to_slot) begin
          e.from_sym = from_slot[7:0];
          e.to_sym   = to_slot[7:0];
          if (sym_start[to_slot] == w.target_pc) begin
            // landing on a function start is a call
            if (depth >= STACK_DEPTH) begin
              e.kind = crt_pkg::EV_OVERFLOW;
            end else begin
              ret_stack[depth] = ret_addr;
              depth++;
              e.kind = crt_pkg::EV_CALL;
            end
          end else begin
            // return: topmost matching entry and all above it go
            found = 1'b0;
            d = depth;
            while (d > 0 && !found) begin
              d--;
              if (ret_stack[d] == w.target_pc) found = 1'b1;
            end
            if (found) begin
              depth = d;
              e.kind = crt_pkg::EV_RETURN;
            end else begin
              e.kind = crt_pkg::EV_UNMATCHED;
            end
          end
        end
      end
      e.depth = depth[7:0];
      expected_events.push_back(e);
    endfunction

    function void check_event(trace_event_t got);
      trace_event_t want;
      if (expected_events.size() == 0) begin
        flag_error($sformatf("unexpected result word: kind %0d from %0d to %0d depth %0d",
                             got.kind, got.from_sym, got.to_sym, got.depth));
        return;
      end
      want = expected_events.pop_front();
      checked++;
      case (want.kind)
        crt_pkg::EV_CALL:      calls++;
        crt_pkg::EV_RETURN:    returns++;
        crt_pkg::EV_OVERFLOW:  overflows++;
        crt_pkg::EV_UNMATCHED: unmatched++;
        default: ;
      endcase
      if (got.kind !== want.kind || got.from_sym !== want.from_sym ||
          got.to_sym !== want.to_sym || got.depth !== want.depth)
        flag_error($sformatf({"result %0d mismatch: expected kind %0d from %0d to %0d ",
                              "depth %0d, got kind %0d from %0d to %0d depth %0d"},
                             checked, want.kind, want.from_sym, want.to_sym, want.depth,
                             got.kind, got.from_sym, got.to_sym, got.depth));
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             symbol_count_we = 1'b0;
  logic [crt_pkg::COUNT_W-1:0]      symbol_count_wdata = '0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  logic [crt_pkg::IN_TDATA_W-1:0]   s_axis_tdata = '0;   // index, start, length, is_func, pc, target
  logic                             s_axis_tuser = 1'b0; // op
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  logic [crt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;        // from_symbol, to_symbol, call_depth
  logic [crt_pkg::KIND_W-1:0]       m_axis_tuser;        // event_kind

  call_trace_scoreboard sb;
  int          send_idle_pct = 31;
  int          recv_idle_pct = 56;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;

  call_return_tracer i_dut (
    .clk                (clk),
    .rst                (rst),
    .symbol_count_we    (symbol_count_we),
    .symbol_count_wdata (symbol_count_wdata),
    .s_axis_tvalid      (s_axis_tvalid),
    .s_axis_tready      (s_axis_tready),
    .s_axis_tdata       (s_axis_tdata),
    .s_axis_tuser       (s_axis_tuser),
    .m_axis_tvalid      (m_axis_tvalid),
    .m_axis_tready      (m_axis_tready),
    .m_axis_tdata       (m_axis_tdata),
    .m_axis_tuser       (m_axis_tuser)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) cycles <= cycles + 1;

  // receiver back-pressure
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // result monitor
  always @(posedge clk) begin : result_monitor
    trace_event_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.kind     = crt_pkg::event_kind_t'(m_axis_tuser);
      got.from_sym = m_axis_tdata[7:0];
      got.to_sym   = m_axis_tdata[15:8];
      got.depth    = m_axis_tdata[23:16];
      sb.check_event(got);
    end
  end

  // watchdog
  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles", cycles);
    $display("*** FAILED ***");
    $finish;
  end

  // Called at a falling edge; returns at the falling edge after acceptance
  task automatic send_word(logic op, trace_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= IN_W'(w);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_word(op, w);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic load_symbol(int unsigned slot, logic [31:0] start, logic [31:0] length,
                             logic is_func);
    trace_word_t w;
    w.index       = slot[7:0];
    w.start       = start;
    w.length      = length;
    w.is_function = is_func;
    w.current_pc  = $urandom;
    w.target_pc   = $urandom;
    send_word(crt_pkg::OP_LOAD, w);
  endtask

  task automatic send_transfer(logic [31:0] pc, logic [31:0] target);
    trace_word_t w;
    w.index       = 8'($urandom_range(255));
    w.start       = $urandom;
    w.length      = $urandom;
    w.is_function = 1'($urandom_range(1));
    w.current_pc  = pc;
    w.target_pc   = target;
    send_word(crt_pkg::OP_TRANSFER, w);
  endtask

  // drop valid and wait for every outstanding result word
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_events.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_symbol_count(int unsigned v);
    wait_idle();
    symbol_count_we    <= 1'b1;
    symbol_count_wdata <= v[8:0];
    @(negedge clk);
    symbol_count_we    <= 1'b0;
    sb.symbol_count = v;
  endtask

  function automatic logic [31:0] pc_within(int unsigned slot);
    if (sb.sym_length[slot] == 0) return sb.sym_start[slot];
    return sb.sym_start[slot] + ($urandom % sb.sym_length[slot]);
  endfunction

  // fresh table: evenly spaced ranges from a random base
  task automatic load_layout();
    int unsigned stride;
    logic [31:0] base;
    logic [31:0] len;
    int          r;
    stride = 1 << $urandom_range(16, 8);
    base   = $urandom;
    for (int unsigned i = 0; i < SYMS; i++) begin
      r = $urandom_range(99);
      if (r < 4) len = '0;
      else if (r < 9) len = $urandom;
      else len = $urandom_range(stride, 8);
      load_symbol(i, base + 32'(i * stride), len, $urandom_range(99) < 88);
    end
  endtask

  // mostly calls and returns that follow the predicted stack
  task automatic random_trace_word(int unsigned lim);
    int          r;
    int unsigned f, t, k;
    logic [31:0] p;
    r = $urandom_range(99);
    f = $urandom_range(lim - 1);
    t = $urandom_range(lim - 1);
    if (r < 5) begin
      load_symbol($urandom_range(lim - 1), $urandom, $urandom_range(65536, 1),
                  1'($urandom_range(1)));
    end else if (r < 45) begin
      send_transfer(pc_within(f), sb.sym_start[t]);
    end else if (r < 75) begin
      if (sb.depth == 0) begin
        send_transfer(pc_within(f), pc_within(t));
      end else begin
        k = ($urandom_range(99) < 70) ? sb.depth - 1 : $urandom_range(sb.depth - 1);
        send_transfer(pc_within(f), sb.ret_stack[k]);
      end
    end else if (r < 83) begin
      send_transfer(pc_within(f), pc_within(t));
    end else if (r < 88) begin
      p = pc_within(f);
      send_transfer(p, p + 32'd4);
    end else if (r < 93) begin
      send_transfer(pc_within(f), pc_within(f));
    end else begin
      send_transfer($urandom, $urandom);
    end
  endtask

  task automatic run_phase(int unsigned count, int unsigned n);
    int unsigned lim;
    write_symbol_count(count);
    lim = (count > SYMS) ? SYMS : count;
    if (lim == 0) lim = 1;
    repeat (n) random_trace_word(lim);
  endtask

  initial begin
    sb = new();
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // nothing searched yet
    send_transfer(32'h0000_0000, 32'h0000_1000);

    // small hand-built table: plain, top of memory, empty, data, overlap, top slot
    load_symbol(0, 32'h0000_0000, 32'h0000_0100, 1'b1);
    load_symbol(1, 32'h0000_1000, 32'h0000_0100, 1'b1);
    load_symbol(2, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1);
    load_symbol(3, 32'h0000_2000, 32'h0000_0000, 1'b1);
    load_symbol(4, 32'h0000_3000, 32'h0000_0100, 1'b0);
    load_symbol(5, 32'h0000_1000, 32'h0000_0800, 1'b1);
    load_symbol(255, 32'hA5A5_0000, 32'h0000_0040, 1'b1);
    write_symbol_count(6);

    send_transfer(32'h0000_0010, 32'h0000_0014);  // fall-through
    send_transfer(32'h0000_0010, 32'h0000_1000);  // call
    send_transfer(32'h0000_1010, 32'h0000_1020);  // same function
    send_transfer(32'h0000_1010, 32'hFFFF_FF00);  // call to top of memory
    send_transfer(32'hFFFF_FFFC, 32'h0000_0000);  // fall-through wrapping at 2^32
    send_transfer(32'hFFFF_FF10, 32'h0000_1014);  // matched return
    send_transfer(32'h0000_1020, 32'h0000_3010);  // target not a function
    send_transfer(32'h0000_1020, 32'h0000_2000);  // zero-length range
    send_transfer(32'h0000_1020, 32'h0000_1200);  // return with no match
    send_transfer(32'h0000_1020, 32'h0000_0014);  // return to depth 0
    send_transfer(32'h0000_1020, 32'h0000_0050);  // return on empty stack
    send_transfer(32'hFFFF_FFFF, 32'h0000_1000);  // return address wraps
    send_transfer(32'h0000_1004, 32'h0000_0003);
    send_transfer(32'h0000_0010, 32'h0000_1000);
    send_transfer(32'h0000_1010, 32'hFFFF_FF00);
    send_transfer(32'hFFFF_FF20, 32'h0000_0014);  // pops two frames

    // fill the stack past its end, then unwind to the bottom frame
    send_transfer(32'h0000_1200, 32'h0000_0000);
    for (int i = 1; i < 130; i++) begin
      if (i % 2) send_transfer(32'h0000_0010, 32'h0000_1000);
      else send_transfer(32'h0000_1010, 32'h0000_0000);
    end
    send_transfer(32'h0000_1020, 32'h0000_1300);
    send_transfer(32'h0000_1020, 32'h0000_1204);
    wait_idle();

    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          send_idle_pct = 31;
          recv_idle_pct = 56;
        end
        1: begin
          send_idle_pct = 56;
          recv_idle_pct = 31;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      load_layout();
      run_phase($urandom_range(16, 2), 50);
      run_phase(SYMS, 20);
      run_phase($urandom_range(16, 2), 50);
      run_phase(511, 20);
      run_phase(1, 10);
      run_phase($urandom_range(16, 2), 50);
      run_phase(0, 10);
    end

    wait_idle();
    repeat (END_SLACK) @(posedge clk);
    if (sb.expected_events.size() != 0)
      sb.flag_error($sformatf("%0d expected result words never arrived",
                              sb.expected_events.size()));

    $display("sent %0d words, checked %0d results over table sizes 0..511 and 3 idle mixes",
             words_sent, sb.checked);
    $display("calls %0d, returns %0d, overflows %0d, unmatched returns %0d, errors %0d",
             sb.calls, sb.returns, sb.overflows, sb.unmatched, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
src/crt_pkg.sv
src/crt_range_unit.sv
src/call_return_tracer.sv
bench/call_return_tracer_tb.sv
